// ===== rtl/core/sabs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// summed-area box sum package
// shared sizes, codes and the table memory request/response types
// ----------------------------------------------------------------------------
package sabs_pkg;

  localparam int MaxRows    = 64;
  localparam int MaxCols    = 64;
  localparam int ValueW     = 32;

  localparam int RowW       = $clog2(MaxRows);
  localparam int ColW       = $clog2(MaxCols);
  localparam int RowCntW    = RowW + 1;
  localparam int ColCntW    = ColW + 1;
  localparam int AddrW      = RowW + ColW;
  localparam int TableDepth = MaxRows * MaxCols;

  localparam int CfgW       = 7;
  localparam int CfgIdxW    = 1;
  localparam int StatusW    = 2;

  localparam logic [CfgIdxW-1:0] CfgRowsIdx = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgColsIdx = 1'b1;

  typedef enum logic {
    ModeLoad  = 1'b0,
    ModeQuery = 1'b1
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk       = 2'd0,
    StatusBadRect  = 2'd1,
    StatusNotReady = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StLoadWrite,
    StQueryFirst,
    StQuerySecond,
    StQueryEnd
  } state_e;

  // port a reads or writes, port b reads only
  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  addr_a;
    logic [ValueW-1:0] wdata;
    logic [AddrW-1:0]  addr_b;
  } ram_req_t;

  typedef struct packed {
    logic [ValueW-1:0] rdata_a;
    logic [ValueW-1:0] rdata_b;
  } ram_rsp_t;

endpackage

// ===== rtl/core/sabs_table_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// summed-area table memory
// one read/write port and one read port, registered read data; a read on
// port b of the entry written on port a in the same cycle returns new data
// ----------------------------------------------------------------------------
module sabs_table_ram import sabs_pkg::*; (
  input  logic     clk_i,
  input  ram_req_t req_i,
  output ram_rsp_t rsp_o
);

  logic [ValueW-1:0] mem_q [TableDepth];
  logic [ValueW-1:0] rdata_a_q;
  logic [ValueW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr_a] <= req_i.wdata;
    end
    rdata_a_q <= mem_q[req_i.addr_a];
  end

  // write-through to port b
  always_ff @(posedge clk_i) begin
    if (req_i.we && (req_i.addr_a == req_i.addr_b)) begin
      rdata_b_q <= req_i.wdata;
    end else begin
      rdata_b_q <= mem_q[req_i.addr_b];
    end
  end

  assign rsp_o.rdata_a = rdata_a_q;
  assign rsp_o.rdata_b = rdata_b_q;

endmodule

// ===== rtl/core/summed_area_box_sum_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// summed-area box sum unit
// builds a 2-d prefix sum table from row-major element loads and answers
// rectangle sum queries from four table reads
// ----------------------------------------------------------------------------
//
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------------------
//  request   | start_i / busy_o      | mode_i, element_value_i, top_row_i,
//            |                       | left_col_i, bottom_row_i, right_col_i
//  result    | done_o (one cycle)    | box_sum_o, query_status_o
//  config    | cfg_we_i, cfg_idx_i   | cfg_wdata_i (0 rows_in_use, 1 cols_in_use)
//
//  on a load request the entry above is read from port b of the
//  table memory at accept, the new entry is written on port a the next cycle
//  a query request does paired reads on both memory ports in StQueryFirst and
//  StQuerySecond, then the final add in StQueryEnd; the result strobe comes in
//  the cycle after that; the next request may be accepted in the StQueryEnd cycle
//  reset clears the load position, running sum, ready flag and configuration
//  to 64 x 64; the table memory itself is not cleared
//  results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module summed_area_box_sum_unit import sabs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // request
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     mode_i,
  input  logic signed [ValueW-1:0] element_value_i,
  input  logic [RowW-1:0]          top_row_i,
  input  logic [ColW-1:0]          left_col_i,
  input  logic [RowW-1:0]          bottom_row_i,
  input  logic [ColW-1:0]          right_col_i,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgW-1:0]          cfg_wdata_i,
  // result
  output logic                     done_o,
  output logic signed [ValueW-1:0] box_sum_o,
  output logic [StatusW-1:0]       query_status_o
);

  // effective size: zero acts as one, anything above the maximum is clipped
  function automatic logic [RowCntW-1:0] eff_rows(input logic [CfgW-1:0] val);
    logic [RowCntW-1:0] res;
    if (val == '0) begin
      res = RowCntW'(1);
    end else if (val > CfgW'(MaxRows)) begin
      res = RowCntW'(MaxRows);
    end else begin
      res = RowCntW'(val);
    end
    return res;
  endfunction

  function automatic logic [ColCntW-1:0] eff_cols(input logic [CfgW-1:0] val);
    logic [ColCntW-1:0] res;
    if (val == '0) begin
      res = ColCntW'(1);
    end else if (val > CfgW'(MaxCols)) begin
      res = ColCntW'(MaxCols);
    end else begin
      res = ColCntW'(val);
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // declarations
  // --------------------------------------------------------------------------
  state_e             state_q, state_d;

  logic [CfgW-1:0]    rows_in_use_q, cols_in_use_q;
  logic [RowCntW-1:0] rows_eff;
  logic [ColCntW-1:0] cols_eff;

  logic [RowW-1:0]    load_row_q, load_row_d;
  logic [ColW-1:0]    load_col_q, load_col_d;
  logic [ValueW-1:0]  row_sum_q, row_sum_d;
  logic               table_ready_q, table_ready_d;

  logic [AddrW-1:0]   wr_addr_q;
  logic [ValueW-1:0]  wr_sum_q;

  logic [RowW-1:0]    top_q, bottom_q;
  logic [ColW-1:0]    left_q, right_q;
  status_e            status_q, status_d;
  logic [ValueW-1:0]  partial_q;

  logic               done_q;
  logic [ValueW-1:0]  box_sum_q;
  status_e            status_out_q;

  logic               accept, load_accept, query_accept;
  logic [RowW-1:0]    ld_row;
  logic [ColW-1:0]    ld_col;
  logic [ValueW-1:0]  ld_sum;
  logic               ld_col_last, ld_row_last;

  logic               top_zero, left_zero;
  logic [ValueW-1:0]  term_b1, term_a2, term_b2;
  logic [ValueW-1:0]  partial_d, final_sum;
  logic [ValueW-1:0]  above_val;

  ram_req_t           ram_req;
  ram_rsp_t           ram_rsp;

  // --------------------------------------------------------------------------
  // request handshake
  // --------------------------------------------------------------------------
  assign accept       = start_i && !busy_o;
  assign load_accept  = accept && (mode_i == ModeLoad);
  assign query_accept = accept && (mode_i == ModeQuery);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_in_use_q <= CfgW'(MaxRows);
      cols_in_use_q <= CfgW'(MaxCols);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRowsIdx: rows_in_use_q <= cfg_wdata_i;
        CfgColsIdx: cols_in_use_q <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  assign rows_eff = eff_rows(rows_in_use_q);
  assign cols_eff = eff_cols(cols_in_use_q);

  // --------------------------------------------------------------------------
  // load position and running row sum
  // --------------------------------------------------------------------------
  assign ld_row = ({1'b0, load_row_q} >= rows_eff) ? RowW'(rows_eff - 1'b1) : load_row_q;
  assign ld_col = ({1'b0, load_col_q} >= cols_eff) ? ColW'(cols_eff - 1'b1) : load_col_q;
  assign ld_sum = row_sum_q + ValueW'($unsigned(element_value_i));
  assign ld_col_last = ({1'b0, ld_col} + ColCntW'(1)) >= cols_eff;
  assign ld_row_last = ({1'b0, ld_row} + RowCntW'(1)) >= rows_eff;

  always_comb begin
    load_row_d    = load_row_q;
    load_col_d    = load_col_q;
    row_sum_d     = row_sum_q;
    table_ready_d = table_ready_q;
    if (cfg_we_i) begin
      // any register write restarts the matrix
      load_row_d    = '0;
      load_col_d    = '0;
      row_sum_d     = '0;
      table_ready_d = 1'b0;
    end else if (load_accept) begin
      table_ready_d = 1'b0;
      if (ld_col_last) begin
        row_sum_d  = '0;
        load_col_d = '0;
        if (ld_row_last) begin
          load_row_d    = '0;
          table_ready_d = 1'b1;
        end else begin
          load_row_d = ld_row + 1'b1;
        end
      end else begin
        row_sum_d  = ld_sum;
        load_col_d = ld_col + 1'b1;
        load_row_d = ld_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_row_q    <= '0;
      load_col_q    <= '0;
      row_sum_q     <= '0;
      table_ready_q <= 1'b0;
    end else begin
      load_row_q    <= load_row_d;
      load_col_q    <= load_col_d;
      row_sum_q     <= row_sum_d;
      table_ready_q <= table_ready_d;
    end
  end

  // pending table write of the load in flight
  always_ff @(posedge clk_i) begin
    if (load_accept) begin
      wr_addr_q <= {ld_row, ld_col};
      wr_sum_q  <= ld_sum;
    end
  end

  // --------------------------------------------------------------------------
  // query capture and status check
  // --------------------------------------------------------------------------
  always_comb begin
    if (!table_ready_q) begin
      status_d = StatusNotReady;
    end else if ((top_row_i > bottom_row_i) || (left_col_i > right_col_i) ||
                 ({1'b0, bottom_row_i} >= rows_eff) ||
                 ({1'b0, right_col_i} >= cols_eff)) begin
      status_d = StatusBadRect;
    end else begin
      status_d = StatusOk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_accept) begin
      top_q    <= top_row_i;
      left_q   <= left_col_i;
      bottom_q <= bottom_row_i;
      right_q  <= right_col_i;
      status_q <= status_d;
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle, StQueryEnd: begin
        if (load_accept) begin
          state_d = StLoadWrite;
        end else if (query_accept) begin
          state_d = StQueryFirst;
        end else begin
          state_d = StIdle;
        end
      end
      StLoadWrite:   state_d = StIdle;
      StQueryFirst:  state_d = StQuerySecond;
      StQuerySecond: state_d = StQueryEnd;
      default:       state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // the border row above row 0 reads as zero
  assign above_val = (wr_addr_q[AddrW-1 -: RowW] == '0) ? '0 : ram_rsp.rdata_b;

  always_comb begin
    busy_o         = 1'b0;
    ram_req.we     = 1'b0;
    ram_req.addr_a = wr_addr_q;
    ram_req.wdata  = above_val + wr_sum_q;
    // entry above the element being loaded
    ram_req.addr_b = {ld_row - 1'b1, ld_col};
    unique case (state_q)
      StLoadWrite: begin
        busy_o     = 1'b1;
        ram_req.we = 1'b1;
      end
      StQueryFirst: begin
        busy_o         = 1'b1;
        ram_req.addr_a = {bottom_q, right_q};
        ram_req.addr_b = {top_q - 1'b1, right_q};
      end
      StQuerySecond: begin
        busy_o         = 1'b1;
        ram_req.addr_a = {bottom_q, left_q - 1'b1};
        ram_req.addr_b = {top_q - 1'b1, left_q - 1'b1};
      end
      default: ;
    endcase
  end

  sabs_table_ram u_table (
    .clk_i (clk_i),
    .req_i (ram_req),
    .rsp_o (ram_rsp)
  );

  // --------------------------------------------------------------------------
  // box sum: P(b,r) - P(t-1,r) first, then - P(b,l-1) + P(t-1,l-1)
  // --------------------------------------------------------------------------
  assign top_zero  = (top_q == '0);
  assign left_zero = (left_q == '0);
  assign term_b1   = top_zero ? '0 : ram_rsp.rdata_b;
  assign term_a2   = left_zero ? '0 : ram_rsp.rdata_a;
  assign term_b2   = (top_zero || left_zero) ? '0 : ram_rsp.rdata_b;
  assign partial_d = ram_rsp.rdata_a - term_b1;
  assign final_sum = partial_q - term_a2 + term_b2;

  always_ff @(posedge clk_i) begin
    if (state_q == StQuerySecond) begin
      partial_q <= partial_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == StQueryEnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StQueryEnd) begin
      box_sum_q    <= (status_q == StatusOk) ? final_sum : '0;
      status_out_q <= status_q;
    end
  end

  assign done_o         = done_q;
  assign box_sum_o      = $signed(box_sum_q);
  assign query_status_o = status_out_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_done_after_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == StQueryEnd))
    else $error("result strobe without a finished query");

  a_load_goes_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_accept |=> (state_q == StLoadWrite))
    else $error("accepted load did not reach the write cycle");

  a_error_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (query_status_o != StatusOk)) |-> (box_sum_o == '0))
    else $error("error result carries a non-zero sum");

  a_ready_drop_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(table_ready_q) |-> $past(cfg_we_i || load_accept))
    else $error("table ready dropped without a load or register write");

endmodule

// ===== verif/summed_area_box_sum_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// summed-area box sum unit testbench
// loads matrices of many shapes through the request port, asks rectangle
// queries against them and compares every result with a local model of the
// prefix table, with random gaps between requests and register writes
// between phases
// ----------------------------------------------------------------------------
module summed_area_box_sum_unit_test;
  import sabs_pkg::*;

  localparam int ItemTarget    = 1650;
  localparam int ReportLimit   = 10;
  localparam int SettleCycles  = 4;
  localparam int DrainCycles   = 8;
  localparam int WatchdogLimit = 2000;
  localparam int PhaseCells    = 256;

  typedef struct packed {
    mode_e             mode;
    logic [ValueW-1:0] value;
    logic [RowW-1:0]   top_row;
    logic [ColW-1:0]   left_col;
    logic [RowW-1:0]   bottom_row;
    logic [ColW-1:0]   right_col;
  } box_request_t;

  typedef struct packed {
    logic [ValueW-1:0] sum;
    status_e           status;
  } box_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic                     mode_i;
  logic signed [ValueW-1:0] element_value_i;
  logic [RowW-1:0]          top_row_i;
  logic [ColW-1:0]          left_col_i;
  logic [RowW-1:0]          bottom_row_i;
  logic [ColW-1:0]          right_col_i;
  logic                     cfg_we_i;
  logic [CfgIdxW-1:0]       cfg_idx_i;
  logic [CfgW-1:0]          cfg_wdata_i;
  logic                     done_o;
  logic signed [ValueW-1:0] box_sum_o;
  logic [StatusW-1:0]       query_status_o;

  summed_area_box_sum_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .element_value_i(element_value_i),
    .top_row_i      (top_row_i),
    .left_col_i     (left_col_i),
    .bottom_row_i   (bottom_row_i),
    .right_col_i    (right_col_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .box_sum_o      (box_sum_o),
    .query_status_o (query_status_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // a request moves at an edge where start is high and the unit is free
  wire req_taken = start_i && !busy_o;

  // --------------------------------------------------------------------------
  // local copy of the unit's state
  // --------------------------------------------------------------------------
  logic [ValueW-1:0] prefix_mem [TableDepth];
  int                fill_row;
  int                fill_col;
  logic [ValueW-1:0] row_acc;
  logic              table_full;
  logic [CfgW-1:0]   rows_reg;
  logic [CfgW-1:0]   cols_reg;

  box_request_t pending_requests [$];
  box_result_t  box_results_due [$];

  int n_queued = 0;
  int n_loads = 0;
  int n_queries = 0;
  int n_cfg_writes = 0;
  int n_ok = 0;
  int n_bad_rect = 0;
  int n_unready = 0;
  int fail_count = 0;

  // register value as the unit uses it: zero acts as one, big values clip
  function automatic int used_size(input logic [CfgW-1:0] setting, input int cap);
    if (setting == 0) return 1;
    if (setting > cap) return cap;
    return int'(setting);
  endfunction

  // prefix table read with the zero border above row 0 and left of column 0
  function automatic logic [ValueW-1:0] corner(input int r, input int c);
    if (r < 0 || c < 0) return '0;
    return prefix_mem[r * MaxCols + c];
  endfunction

  // one accepted request: a load updates the table, a query yields a result
  task automatic advance_table(input box_request_t rq);
    int          nr;
    int          nc;
    int          r;
    int          c;
    int          t;
    int          l;
    int          b;
    int          rc;
    box_result_t res;
    nr = used_size(rows_reg, MaxRows);
    nc = used_size(cols_reg, MaxCols);
    if (rq.mode == ModeLoad) begin
      n_loads++;
      r = (fill_row >= nr) ? nr - 1 : fill_row;
      c = (fill_col >= nc) ? nc - 1 : fill_col;
      row_acc = row_acc + rq.value;
      prefix_mem[r * MaxCols + c] = corner(r - 1, c) + row_acc;
      table_full = 1'b0;
      if (c + 1 >= nc) begin
        // end of row: running sum restarts, last row completes the matrix
        row_acc  = '0;
        fill_col = 0;
        if (r + 1 >= nr) begin
          fill_row   = 0;
          table_full = 1'b1;
        end else begin
          fill_row = r + 1;
        end
      end else begin
        fill_col = c + 1;
        fill_row = r;
      end
    end else begin
      n_queries++;
      t  = int'(rq.top_row);
      l  = int'(rq.left_col);
      b  = int'(rq.bottom_row);
      rc = int'(rq.right_col);
      res.sum = '0;
      // readiness is judged before the rectangle
      if (!table_full) begin
        res.status = StatusNotReady;
      end else if (t > b || l > rc || b >= nr || rc >= nc) begin
        res.status = StatusBadRect;
      end else begin
        res.status = StatusOk;
        res.sum = corner(b, rc) - corner(t - 1, rc) - corner(b, l - 1)
                  + corner(t - 1, l - 1);
      end
      box_results_due.push_back(res);
    end
  endtask

  // --------------------------------------------------------------------------
  // driver: bursts of requests with random gaps between bursts
  // --------------------------------------------------------------------------
  box_request_t held_req;
  logic         holding = 1'b0;
  int           gap_left = 0;
  int           burst_left = 1;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_taken) begin
        advance_table(held_req);
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap_left != 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          held_req = pending_requests.pop_front();
          holding  = 1'b1;
          start_i         <= 1'b1;
          mode_i          <= held_req.mode;
          element_value_i <= held_req.value;
          top_row_i       <= held_req.top_row;
          left_col_i      <= held_req.left_col;
          bottom_row_i    <= held_req.bottom_row;
          right_col_i     <= held_req.right_col;
          burst_left--;
          if (burst_left <= 0) begin
            // half the bursts run straight into the next one
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
              0: gap_left = $urandom_range(1, 3);
              1: gap_left = $urandom_range(4, 12);
              default: gap_left = 0;
            endcase
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: each strobed result against the oldest expected one
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    box_result_t want;
    if (rst_ni && done_o) begin
      if (box_results_due.size() == 0) begin
        if (fail_count < ReportLimit)
          $display("unexpected result: sum %0d status %0d", box_sum_o, query_status_o);
        fail_count++;
      end else begin
        want = box_results_due.pop_front();
        case (want.status)
          StatusOk:      n_ok++;
          StatusBadRect: n_bad_rect++;
          default:       n_unready++;
        endcase
        if (box_sum_o !== want.sum || query_status_o !== want.status) begin
          if (fail_count < ReportLimit)
            $display("mismatch: expected sum %0d status %0d, got sum %0d status %0d",
                     $signed(want.sum), want.status, box_sum_o, query_status_o);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without a request, a result or a register write
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || req_taken || done_o || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no progress for %0d cycles", WatchdogLimit);
        $display("** summed_area_box_sum_unit: FAILED **");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_load(input logic [ValueW-1:0] v);
    box_request_t rq;
    rq.mode       = ModeLoad;
    rq.value      = v;
    rq.top_row    = RowW'($urandom);
    rq.left_col   = ColW'($urandom);
    rq.bottom_row = RowW'($urandom);
    rq.right_col  = ColW'($urandom);
    pending_requests.push_back(rq);
    n_queued++;
  endtask

  task automatic push_query(input int t, input int l, input int b, input int rc);
    box_request_t rq;
    rq.mode       = ModeQuery;
    rq.value      = $urandom;
    rq.top_row    = RowW'(t);
    rq.left_col   = ColW'(l);
    rq.bottom_row = RowW'(b);
    rq.right_col  = ColW'(rc);
    pending_requests.push_back(rq);
    n_queued++;
  endtask

  // element values: full range, small mixed signs, or the wrap extremes
  function automatic logic [ValueW-1:0] pick_value(input int kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 200) - 100;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'hffff_ffff;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // everything queued has gone through and no result is outstanding
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_requests.size() != 0 || holding || busy_o ||
           box_results_due.size() != 0);
    // a load just accepted may still be writing the table
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_setting(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgRowsIdx) rows_reg = val;
    else cols_reg = val;
    // any write restarts loading from the top left
    fill_row   = 0;
    fill_col   = 0;
    row_acc    = '0;
    table_full = 1'b0;
    n_cfg_writes++;
  endtask

  task automatic load_run(input int count, input int kind);
    repeat (count) push_load(pick_value(kind));
  endtask

  // mostly well-formed rectangles, the rest random corners
  task automatic ask_queries(input int count);
    int nr;
    int nc;
    int t;
    int l;
    nr = used_size(rows_reg, MaxRows);
    nc = used_size(cols_reg, MaxCols);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) begin
        push_query($urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom_range(0, 63));
      end else begin
        t = $urandom_range(0, nr - 1);
        l = $urandom_range(0, nc - 1);
        push_query(t, l, $urandom_range(t, nr - 1), $urandom_range(l, nc - 1));
      end
    end
  endtask

  // one full matrix, sometimes interrupted by a not-ready query, then queries
  task automatic run_round();
    int n;
    int k;
    int kind;
    n    = used_size(rows_reg, MaxRows) * used_size(cols_reg, MaxCols);
    kind = $urandom_range(0, 2);
    if (n > 1 && $urandom_range(0, 3) == 0) begin
      k = $urandom_range(1, n - 1);
      load_run(k, kind);
      ask_queries(1);
      load_run(n - k, kind);
    end else begin
      load_run(n, kind);
    end
    ask_queries($urandom_range(3, 10));
  endtask

  function automatic logic [CfgW-1:0] pick_setting();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CfgW'($urandom_range(65, 127));
      2: return CfgW'($urandom_range(9, 16));
      default: return CfgW'($urandom_range(1, 8));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // reset, directed checks, register extremes, then random phases
  // --------------------------------------------------------------------------
  initial begin
    int n;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    mode_i          = ModeLoad;
    element_value_i = '0;
    top_row_i       = '0;
    left_col_i      = '0;
    bottom_row_i    = '0;
    right_col_i     = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CfgRowsIdx;
    cfg_wdata_i     = '0;
    fill_row        = 0;
    fill_col        = 0;
    row_acc         = '0;
    table_full      = 1'b0;
    rows_reg        = 7'd64;
    cols_reg        = 7'd64;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // queries straight after reset, nothing loaded
    push_query(63, 63, 63, 63);
    push_query(0, 0, 0, 0);

    // zero rows acts as one row; 1 x 3 with values that wrap the sum
    write_setting(CfgRowsIdx, 7'd0);
    write_setting(CfgColsIdx, 7'd3);
    push_load(32'h7fff_ffff);
    push_load(32'h8000_0000);
    push_load(32'hffff_ffff);
    push_query(0, 0, 0, 2);
    push_query(0, 1, 0, 1);
    push_query(0, 0, 1, 0);   // bottom outside rows in use
    push_query(0, 0, 0, 3);   // right outside columns in use
    push_query(0, 2, 0, 1);   // left past right
    // a fresh load drops the ready flag until the matrix is complete again
    push_load(32'd5);
    push_query(0, 0, 0, 0);
    push_load(-32'sd7);
    push_load(32'd9);
    push_query(0, 0, 0, 2);

    // 2 x 2 with the top corner below the bottom one
    write_setting(CfgRowsIdx, 7'd2);
    write_setting(CfgColsIdx, 7'd2);
    push_load(32'd1);
    push_load(32'd2);
    push_load(32'd3);
    push_load(32'h7fff_fffe);
    push_query(1, 0, 0, 1);
    push_query(0, 0, 1, 1);
    push_query(1, 1, 1, 1);

    // register extremes: zero, in-range maximum and values past it
    write_setting(CfgRowsIdx, 7'd100);
    write_setting(CfgColsIdx, 7'd0);
    run_round();
    write_setting(CfgRowsIdx, 7'd0);
    write_setting(CfgColsIdx, 7'd127);
    run_round();
    write_setting(CfgRowsIdx, 7'd64);
    write_setting(CfgColsIdx, 7'd3);
    run_round();
    write_setting(CfgRowsIdx, 7'd2);
    write_setting(CfgColsIdx, 7'd64);
    run_round();

    // random phases: new shape, then one to three matrices against it
    while (n_queued < ItemTarget) begin
      // sometimes leave a matrix half loaded so the write lands mid-load
      n = used_size(rows_reg, MaxRows) * used_size(cols_reg, MaxCols);
      if (n > 1 && $urandom_range(0, 4) == 0) begin
        load_run($urandom_range(1, n - 1), $urandom_range(0, 2));
        ask_queries(1);
      end
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 0) write_setting(CfgRowsIdx, pick_setting());
        else write_setting(CfgColsIdx, pick_setting());
      end else begin
        write_setting(CfgRowsIdx, pick_setting());
        write_setting(CfgColsIdx, pick_setting());
      end
      // keep a random shape small enough that the run stays near its length
      n = used_size(rows_reg, MaxRows) * used_size(cols_reg, MaxCols);
      if (n > PhaseCells) write_setting(CfgColsIdx, CfgW'($urandom_range(1, 4)));
      repeat ($urandom_range(1, 3)) begin
        if (n_queued < ItemTarget) run_round();
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (box_results_due.size() != 0) begin
      $display("%0d expected results never arrived", box_results_due.size());
      fail_count += box_results_due.size();
    end
    $display("covered %0d loads, %0d queries, %0d register writes",
             n_loads, n_queries, n_cfg_writes);
    $display("results: %0d ok, %0d bad rectangle, %0d not loaded; %0d failures",
             n_ok, n_bad_rect, n_unready, fail_count);
    if (fail_count == 0) begin
      $display("** summed_area_box_sum_unit: PASSED **");
    end else begin
      $display("** summed_area_box_sum_unit: FAILED **");
    end
    $finish;
  end

endmodule
